// File: rtl/rau_pkg.sv
// rau_pkg: shared types and constants for the rational arithmetic unit.
// Used by rau_front, rau_core and rational_arithmetic_unit; no dependencies.
package rau_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int OPW         = 32;   // operand field width
  localparam int RW          = 64;   // result numerator width
  localparam int DW          = 63;   // result denominator width

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_CMP = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  // One classified item: operands in sign-magnitude form, zero denominators
  // already replaced by one.
  typedef struct packed {
    logic [2:0]     action;
    logic [OPW-1:0] a_mag;
    logic [OPW-1:0] a_dmag;
    logic           a_neg;
    logic [OPW-1:0] b_mag;
    logic [OPW-1:0] b_dmag;
    logic           b_neg;
    logic           zden;
  } item_t;

endpackage

// File: rtl/rau_front.sv
// rau_front: accepts input words, classifies operands into sign-magnitude
// form and queues them for the core. Depends on rau_pkg.
module rau_front #(
  parameter int DEPTH = rau_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [127:0]         in_tdata,
  input  logic [2:0]           in_tuser,
  output logic                 q_valid,
  input  logic                 q_pop,
  output rau_pkg::item_t       q_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rau_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  rau_pkg::item_t item;
  logic           push;
  logic           pop;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  always_comb begin
    logic [31:0] an, ad, bn, bd;
    an = in_tdata[31:0];
    ad = in_tdata[63:32];
    bn = in_tdata[95:64];
    bd = in_tdata[127:96];
    item.action = in_tuser;
    item.a_mag  = mag32(an);
    item.a_dmag = (ad == '0) ? 32'd1 : mag32(ad);
    item.a_neg  = an[31] ^ ad[31];
    item.b_mag  = mag32(bn);
    item.b_dmag = (bd == '0) ? 32'd1 : mag32(bd);
    item.b_neg  = bn[31] ^ bd[31];
    item.zden   = (ad == '0) || (bd == '0);
  end

  assign in_tready = (cnt_r != CW'(DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

// File: rtl/rau_core.sv
// rau_core: sequencer with a shared binary GCD, a radix-2 divider and a
// 32x32 multiplier; reduces operands, forms the result, reduces it again.
// Depends on rau_pkg.
module rau_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  rau_pkg::item_t           q_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [rau_pkg::RW-1:0]   out_num,
  output logic [rau_pkg::DW-1:0]   out_den,
  output logic                     out_eq,
  output logic [1:0]               out_status
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_GCD   = 10'b0000000010,
    S_DIVX  = 10'b0000000100,
    S_DIVY  = 10'b0000001000,
    S_STORE = 10'b0000010000,
    S_MULN1 = 10'b0000100000,
    S_MULN2 = 10'b0001000000,
    S_MULD  = 10'b0010000000,
    S_COMB  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_A   = 2'd0,
    PH_B   = 2'd1,
    PH_LCM = 2'd2,
    PH_FIN = 2'd3
  } phase_t;

  state_t         state_r, state_nxt;
  phase_t         phase_r, phase_nxt;
  rau_pkg::item_t item_r, item_nxt;
  logic [63:0]    x_r, x_nxt, y_r, y_nxt;
  logic [63:0]    gx_r, gx_nxt, gy_r, gy_nxt, g_r, g_nxt;
  logic [5:0]     k_r, k_nxt;
  logic [63:0]    rem_r, rem_nxt, quo_r, quo_nxt, qx_r, qx_nxt, qy_r, qy_nxt;
  logic [5:0]     dcnt_r, dcnt_nxt;
  logic           neg_r, neg_nxt;
  logic [31:0]    am_r, am_nxt, ad_r, ad_nxt, bm_r, bm_nxt, bd_r, bd_nxt;
  logic           an_neg_r, an_neg_nxt, bn_neg_r, bn_neg_nxt;
  logic [63:0]    n1_r, n1_nxt, n2_r, n2_nxt, dd_r, dd_nxt;
  logic [1:0]     stat_r, stat_nxt;
  logic           eq_r, eq_nxt;
  logic           ov_r, ov_nxt;
  logic [63:0]    onum_r, onum_nxt;
  logic [62:0]    oden_r, oden_nxt;
  logic           oeq_r, oeq_nxt;
  logic [1:0]     ostat_r, ostat_nxt;

  logic [31:0]    mul_a, mul_b;
  logic [63:0]    prod;
  logic [64:0]    dtrial;
  logic           dbit;
  logic [63:0]    drem, dquo;
  logic           is_addsub;

  assign prod      = {32'd0, mul_a} * {32'd0, mul_b};
  assign is_addsub = (item_r.action == rau_pkg::ACT_ADD) ||
                     (item_r.action == rau_pkg::ACT_SUB);

  // One restoring divide step on the shared {rem, quo} register pair.
  assign dtrial = {rem_r, quo_r[63]};
  assign dbit   = (dtrial >= {1'b0, g_r});
  assign drem   = dbit ? 64'(dtrial - {1'b0, g_r}) : dtrial[63:0];
  assign dquo   = {quo_r[62:0], dbit};

  always_comb begin
    logic        ld;
    logic [63:0] ldx, ldy;
    logic [63:0] s1, s2, sum;
    ld  = 1'b0;
    ldx = '0;
    ldy = '0;
    s1  = '0;
    s2  = '0;
    sum = '0;
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    item_nxt   = item_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    gx_nxt     = gx_r;
    gy_nxt     = gy_r;
    g_nxt      = g_r;
    k_nxt      = k_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    qx_nxt     = qx_r;
    qy_nxt     = qy_r;
    dcnt_nxt   = dcnt_r;
    neg_nxt    = neg_r;
    am_nxt     = am_r;
    ad_nxt     = ad_r;
    bm_nxt     = bm_r;
    bd_nxt     = bd_r;
    an_neg_nxt = an_neg_r;
    bn_neg_nxt = bn_neg_r;
    n1_nxt     = n1_r;
    n2_nxt     = n2_r;
    dd_nxt     = dd_r;
    stat_nxt   = stat_r;
    eq_nxt     = eq_r;
    ov_nxt     = ov_r && !out_ready;
    onum_nxt   = onum_r;
    oden_nxt   = oden_r;
    oeq_nxt    = oeq_r;
    ostat_nxt  = ostat_r;
    q_pop      = 1'b0;
    mul_a      = '0;
    mul_b      = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          neg_nxt   = q_item.a_neg;
          phase_nxt = PH_A;
          ld        = 1'b1;
          ldx       = {32'd0, q_item.a_mag};
          ldy       = {32'd0, q_item.a_dmag};
        end
      end
      S_GCD: begin
        // Stein's algorithm: strip shared twos into k, then subtract odds.
        if (gx_r == '0 || gy_r == '0) begin
          g_nxt     = ((gx_r == '0) ? gy_r : gx_r) << k_r;
          rem_nxt   = '0;
          quo_nxt   = x_r;
          dcnt_nxt  = '0;
          state_nxt = S_DIVX;
        end else if (!gx_r[0] && !gy_r[0]) begin
          gx_nxt = gx_r >> 1;
          gy_nxt = gy_r >> 1;
          k_nxt  = k_r + 1'b1;
        end else if (!gx_r[0]) begin
          gx_nxt = gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_nxt = gy_r >> 1;
        end else if (gx_r >= gy_r) begin
          gx_nxt = (gx_r - gy_r) >> 1;
        end else begin
          gy_nxt = (gy_r - gx_r) >> 1;
        end
      end
      S_DIVX: begin
        rem_nxt  = drem;
        quo_nxt  = dquo;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 6'd63) begin
          qx_nxt    = dquo;
          rem_nxt   = '0;
          quo_nxt   = y_r;
          dcnt_nxt  = '0;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        rem_nxt  = drem;
        quo_nxt  = dquo;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 6'd63) begin
          qy_nxt    = dquo;
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        case (phase_r)
          PH_A: begin
            am_nxt     = qx_r[31:0];
            ad_nxt     = qy_r[31:0];
            an_neg_nxt = neg_r && (qx_r != '0);
            neg_nxt    = item_r.b_neg;
            phase_nxt  = PH_B;
            ld         = 1'b1;
            ldx        = {32'd0, item_r.b_mag};
            ldy        = {32'd0, item_r.b_dmag};
          end
          PH_B: begin
            bm_nxt     = qx_r[31:0];
            bd_nxt     = qy_r[31:0];
            bn_neg_nxt = neg_r && (qx_r != '0);
            if (is_addsub) begin
              // Reduce (bd, ad) by their GCD: gives both LCM scale factors.
              phase_nxt = PH_LCM;
              ld        = 1'b1;
              ldx       = {32'd0, qy_r[31:0]};
              ldy       = {32'd0, ad_r};
            end else begin
              state_nxt = S_MULN1;
            end
          end
          PH_LCM: begin
            state_nxt = S_MULN1;
          end
          default: begin
            // Hold the reduced result in qx/qy until the output register frees.
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MULN1: begin
        case (item_r.action)
          rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
            mul_a = am_r;
            mul_b = qx_r[31:0];
          end
          rau_pkg::ACT_MUL: begin
            mul_a = am_r;
            mul_b = bm_r;
          end
          rau_pkg::ACT_DIV: begin
            mul_a = am_r;
            mul_b = bd_r;
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        n1_nxt    = prod;
        state_nxt = is_addsub ? S_MULN2 : S_MULD;
      end
      S_MULN2: begin
        mul_a     = bm_r;
        mul_b     = qy_r[31:0];
        n2_nxt    = prod;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        case (item_r.action)
          rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
            mul_a = qy_r[31:0];
            mul_b = bd_r;
          end
          rau_pkg::ACT_MUL: begin
            mul_a = ad_r;
            mul_b = bd_r;
          end
          rau_pkg::ACT_DIV: begin
            mul_a = ad_r;
            mul_b = bm_r;
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        dd_nxt    = prod;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        stat_nxt  = item_r.zden ? rau_pkg::ST_ZERO_DEN : rau_pkg::ST_OK;
        eq_nxt    = 1'b0;
        phase_nxt = PH_FIN;
        ld        = 1'b1;
        ldx       = '0;
        ldy       = 64'd1;
        neg_nxt   = 1'b0;
        case (item_r.action)
          rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
            s1      = an_neg_r ? (64'd0 - n1_r) : n1_r;
            s2      = (bn_neg_r ^ (item_r.action == rau_pkg::ACT_SUB)) ?
                      (64'd0 - n2_r) : n2_r;
            sum     = s1 + s2;
            neg_nxt = sum[63];
            ldx     = sum[63] ? (64'd0 - sum) : sum;
            ldy     = dd_r;
          end
          rau_pkg::ACT_MUL: begin
            neg_nxt = an_neg_r ^ bn_neg_r;
            ldx     = n1_r;
            ldy     = dd_r;
          end
          rau_pkg::ACT_DIV: begin
            neg_nxt = an_neg_r ^ bn_neg_r;
            ldx     = n1_r;
            if (bm_r == '0) begin
              ldy      = 64'd1;
              stat_nxt = rau_pkg::ST_DIV_ZERO;
            end else begin
              ldy = dd_r;
            end
          end
          rau_pkg::ACT_CMP: begin
            eq_nxt = (an_neg_r == bn_neg_r) && (am_r == bm_r) && (ad_r == bd_r);
          end
          default: begin
            eq_nxt = 1'b0;
          end
        endcase
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          onum_nxt  = (neg_r && (qx_r != '0)) ? (64'd0 - qx_r) : qx_r;
          oden_nxt  = qy_r[62:0];
          oeq_nxt   = eq_r;
          ostat_nxt = stat_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ld) begin
      x_nxt     = ldx;
      y_nxt     = ldy;
      gx_nxt    = ldx;
      gy_nxt    = ldy;
      k_nxt     = '0;
      state_nxt = S_GCD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r  <= phase_nxt;
    item_r   <= item_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    gx_r     <= gx_nxt;
    gy_r     <= gy_nxt;
    g_r      <= g_nxt;
    k_r      <= k_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    qx_r     <= qx_nxt;
    qy_r     <= qy_nxt;
    dcnt_r   <= dcnt_nxt;
    neg_r    <= neg_nxt;
    am_r     <= am_nxt;
    ad_r     <= ad_nxt;
    bm_r     <= bm_nxt;
    bd_r     <= bd_nxt;
    an_neg_r <= an_neg_nxt;
    bn_neg_r <= bn_neg_nxt;
    n1_r     <= n1_nxt;
    n2_r     <= n2_nxt;
    dd_r     <= dd_nxt;
    stat_r   <= stat_nxt;
    eq_r     <= eq_nxt;
    onum_r   <= onum_nxt;
    oden_r   <= oden_nxt;
    oeq_r    <= oeq_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign out_valid  = ov_r;
  assign out_num    = onum_r;
  assign out_den    = oden_r;
  assign out_eq     = oeq_r;
  assign out_status = ostat_r;

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (oden_r != '0))
    else $error("result denominator is zero");

  a_eq_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oeq_r) |-> (onum_r == '0 && oden_r == 63'd1 && ostat_r != rau_pkg::ST_DIV_ZERO))
    else $error("equality flag with nonzero result");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GCD && state_nxt == S_DIVX) |=> (g_r != '0))
    else $error("zero gcd fed to divider");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE && q_valid))
    else $error("queue popped while busy");

endmodule

// File: rtl/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level; joins the classify/queue front end
// to the reduction core. Depends on rau_pkg, rau_front and rau_core.
//
//  channel | dir | handshake          | tdata                      | tuser
//  in_     | in  | in_tvalid/tready   | a_num,a_den,b_num,b_den    | action
//  out_    | out | out_tvalid/tready  | result_num,result_den      | is_equal,status
//
// Flow: each item runs three or four GCD-and-divide reductions (operand a,
// operand b, the common denominator for add/subtract, the result). Each is a
// binary GCD followed by two divides by that GCD in the shared divider; the
// divider and the GCD loop dominate the time an item takes.
// Reset: synchronous, active low; clears the queue, sequencer and out_tvalid.
// Stalls: the front queue keeps accepting while the core works, until it is
// full; a finished result waits in the core until the output register is
// free, then the core returns for the next word.
module rational_arithmetic_unit #(
  parameter int QUEUE_DEPTH = rau_pkg::QUEUE_DEPTH   // 2 or more
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic [2:0]   in_tuser,   // action[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // result_num[63:0], result_den[126:64], zero[127]
  output logic [2:0]   out_tuser   // is_equal[0], status[2:1]
);

  logic                        q_valid;
  logic                        q_pop;
  rau_pkg::item_t              q_item;
  logic [rau_pkg::RW-1:0]      res_num;
  logic [rau_pkg::DW-1:0]      res_den;
  logic                        res_eq;
  logic [1:0]                  res_status;

  // Classify and queue incoming words.
  rau_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // Reduce, compute, reduce again, hold the result for the output side.
  rau_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_num    (res_num),
    .out_den    (res_den),
    .out_eq     (res_eq),
    .out_status (res_status)
  );

  assign out_tdata = {1'b0, res_den, res_num};
  assign out_tuser = {res_status, res_eq};

endmodule
